[hw/rtl/qmt_pkg.sv]
// ----------------------------------------------------------------------------
// qmt_pkg
// shared constants for the quantized mode tracker: field widths, bin
// rounding constants, reciprocal multipliers and queue entry layout
// ----------------------------------------------------------------------------
package qmt_pkg;

   localparam int KEY_BITS_DEFAULT   = 12;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int SAMPLE_BITS   = 20;
   localparam int MODE_BITS     = 19;
   localparam int TAG_BITS      = 8;
   localparam int QUEUE_DEPTH   = 4;

   // rounding divide by 10 or 100 through a reciprocal multiply
   localparam int DIVIDEND_BITS = SAMPLE_BITS + 1;
   localparam int RECIP_BITS    = 22;
   localparam int PROD_BITS     = DIVIDEND_BITS + RECIP_BITS;
   localparam int QUOT_BITS     = 17;
   localparam int FINE_SHIFT    = 24;
   localparam int COARSE_SHIFT  = 28;

   localparam logic [RECIP_BITS-1:0]    RECIP_FINE   = 22'd1677722;
   localparam logic [RECIP_BITS-1:0]    RECIP_COARSE = 22'd2684355;
   localparam logic [SAMPLE_BITS-1:0]   FINE_LIMIT   = 20'd1000;
   localparam logic [DIVIDEND_BITS-1:0] FINE_HALF    = 21'd5;
   localparam logic [DIVIDEND_BITS-1:0] COARSE_HALF  = 21'd50;

   localparam int BIN_WIDTH_BITS = 7;
   localparam logic [BIN_WIDTH_BITS-1:0] FINE_WIDTH   = 7'd10;
   localparam logic [BIN_WIDTH_BITS-1:0] COARSE_WIDTH = 7'd100;

   // queue entry: {first, last, fine, key}
   localparam int ENTRY_FLAGS = 3;
   localparam int FLAG_FIRST  = 2;
   localparam int FLAG_LAST   = 1;
   localparam int FLAG_FINE   = 0;

endpackage

[hw/rtl/qmt_ram.sv]
// ----------------------------------------------------------------------------
// qmt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module qmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/qmt_queue.sv]
// ----------------------------------------------------------------------------
// qmt_queue
// small flop based fifo between the front and back parts
// ----------------------------------------------------------------------------
module qmt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[hw/rtl/qmt_front.sv]
// ----------------------------------------------------------------------------
// qmt_front
// accepts samples, tracks the bin precision of the set and turns each
// sample into a saturated bin key through a reciprocal multiply
// ----------------------------------------------------------------------------
module qmt_front
   import qmt_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            hold,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [SAMPLE_BITS-1:0]          req_sample_us,
   input  logic                            req_first,
   input  logic                            req_last,
   output logic                            q_valid,
   input  logic                            q_ready,
   output logic [KEY_BITS+ENTRY_FLAGS-1:0] q_data
);

   localparam logic [QUOT_BITS-1:0] KEY_LIMIT = QUOT_BITS'((1 << KEY_BITS) - 1);

   logic                     fine_sel_ff, fine_sel_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic [PROD_BITS-1:0]     s1_prod_ff;
   logic                     s1_fine_ff;
   logic                     s1_first_ff;
   logic                     s1_last_ff;
   logic                     accept;
   logic                     cur_fine;
   logic [DIVIDEND_BITS-1:0] dividend;
   logic [PROD_BITS-1:0]     prod;
   logic [QUOT_BITS-1:0]     quot;
   logic [KEY_BITS-1:0]      key;

   assign req_ready = !hold && (!s1_valid_ff || q_ready);
   assign accept    = req_valid && req_ready;

   assign cur_fine = req_first ? (req_sample_us < FINE_LIMIT) : fine_sel_ff;
   assign dividend = DIVIDEND_BITS'(req_sample_us) + (cur_fine ? FINE_HALF : COARSE_HALF);
   assign prod     = PROD_BITS'(dividend) * PROD_BITS'(cur_fine ? RECIP_FINE : RECIP_COARSE);

   always_comb begin
      fine_sel_in = fine_sel_ff;
      if (accept && req_first) begin
         fine_sel_in = cur_fine;
      end
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_sel_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         fine_sel_ff <= fine_sel_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_prod_ff  <= prod;
         s1_fine_ff  <= cur_fine;
         s1_first_ff <= req_first;
         s1_last_ff  <= req_last;
      end
   end

   // quotient and saturation to the table top
   assign quot = s1_fine_ff ? QUOT_BITS'(s1_prod_ff >> FINE_SHIFT)
                            : QUOT_BITS'(s1_prod_ff >> COARSE_SHIFT);
   assign key  = (quot > KEY_LIMIT) ? KEY_LIMIT[KEY_BITS-1:0] : quot[KEY_BITS-1:0];

   assign q_valid = s1_valid_ff;
   assign q_data  = {s1_first_ff, s1_last_ff, s1_fine_ff, key};

endmodule

[hw/rtl/qmt_back.sv]
// ----------------------------------------------------------------------------
// qmt_back
// per bin count update against the tagged count store, running best and
// result register; sweeps the store after reset and on epoch wrap
// ----------------------------------------------------------------------------
module qmt_back
   import qmt_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   output logic                            sweeping,
   input  logic                            q_valid,
   output logic                            q_ready,
   input  logic [KEY_BITS+ENTRY_FLAGS-1:0] q_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [MODE_BITS-1:0]            rsp_mode_us,
   output logic                            rsp_mode_found
);

   localparam int WORD_BITS = TAG_BITS + COUNT_BITS;
   localparam int DEPTH     = 1 << KEY_BITS;
   localparam int MULT_BITS = KEY_BITS + BIN_WIDTH_BITS;

   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_SWEEP = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [TAG_BITS-1:0]   EPOCH_MAX = '1;
   localparam logic [TAG_BITS-1:0]   EPOCH_ONE = TAG_BITS'(1);
   localparam logic [KEY_BITS-1:0]   KEY_TOP   = '1;

   logic                  state_ff, state_in;
   logic [KEY_BITS-1:0]   sweep_cnt_ff, sweep_cnt_in;
   logic [TAG_BITS-1:0]   epoch_ff, epoch_in;

   logic                  b_valid_ff, b_valid_in;
   logic [KEY_BITS-1:0]   b_key_ff;
   logic [TAG_BITS-1:0]   b_epoch_ff;
   logic                  b_first_ff;
   logic                  b_last_ff;
   logic                  b_fine_ff;

   logic                  fwd_valid_ff;
   logic [KEY_BITS-1:0]   fwd_key_ff;
   logic [WORD_BITS-1:0]  fwd_word_ff;

   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [KEY_BITS-1:0]   best_key_ff, best_key_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MODE_BITS-1:0]  rsp_mode_ff;
   logic                  rsp_found_ff;

   logic                  head_first, head_last, head_fine;
   logic [KEY_BITS-1:0]   head_key;
   logic                  wrap, pop, start_sweep, b_advance;

   logic                  ram_wr_en;
   logic [KEY_BITS-1:0]   ram_wr_addr;
   logic [WORD_BITS-1:0]  ram_wr_data;
   logic [WORD_BITS-1:0]  ram_rd_data;

   logic [WORD_BITS-1:0]  cur_word;
   logic [COUNT_BITS-1:0] old_cnt, new_cnt;
   logic [COUNT_BITS-1:0] base_cnt;
   logic [KEY_BITS-1:0]   base_key;
   logic                  found;
   logic [MULT_BITS-1:0]  mode_prod;

   assign head_first = q_data[KEY_BITS + FLAG_FIRST];
   assign head_last  = q_data[KEY_BITS + FLAG_LAST];
   assign head_fine  = q_data[KEY_BITS + FLAG_FINE];
   assign head_key   = q_data[KEY_BITS-1:0];

   assign b_advance   = b_valid_ff && (!b_last_ff || !rsp_valid_ff || rsp_ready);
   assign wrap        = q_valid && head_first && (epoch_ff == EPOCH_MAX);
   assign pop         = (state_ff == ST_RUN) && q_valid && !wrap
                        && (!b_valid_ff || b_advance);
   assign start_sweep = (state_ff == ST_RUN) && wrap && !b_valid_ff;

   assign q_ready  = pop;
   assign sweeping = (state_ff == ST_SWEEP);

   // count read-modify-write with forwarding of the write that overlapped the read
   assign cur_word = (fwd_valid_ff && (fwd_key_ff == b_key_ff)) ? fwd_word_ff : ram_rd_data;
   assign old_cnt  = (cur_word[WORD_BITS-1 -: TAG_BITS] == b_epoch_ff)
                     ? cur_word[COUNT_BITS-1:0] : '0;
   assign new_cnt  = (old_cnt == COUNT_MAX) ? COUNT_MAX : old_cnt + 1'b1;
   assign base_cnt = b_first_ff ? '0 : best_cnt_ff;
   assign base_key = b_first_ff ? '0 : best_key_ff;

   always_comb begin
      best_cnt_in = base_cnt;
      best_key_in = base_key;
      if (new_cnt > base_cnt) begin
         best_cnt_in = new_cnt;
         best_key_in = b_key_ff;
      end
   end

   assign found     = (best_cnt_in > COUNT_ONE);
   assign mode_prod = MULT_BITS'(best_key_in)
                      * MULT_BITS'(b_fine_ff ? FINE_WIDTH : COARSE_WIDTH);

   always_comb begin
      if (state_ff == ST_SWEEP) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = b_advance;
         ram_wr_addr = b_key_ff;
         ram_wr_data = {b_epoch_ff, new_cnt};
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      epoch_in     = epoch_ff;
      case (state_ff)
         ST_RUN: begin
            if (start_sweep) begin
               state_in     = ST_SWEEP;
               sweep_cnt_in = '0;
               epoch_in     = '0;
            end else if (pop && head_first) begin
               epoch_in = epoch_ff + 1'b1;
            end
         end
         ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == KEY_TOP) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_advance && b_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         epoch_ff     <= EPOCH_ONE;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         best_cnt_ff  <= '0;
         best_key_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         epoch_ff     <= epoch_in;
         b_valid_ff   <= b_valid_in;
         fwd_valid_ff <= b_advance || (fwd_valid_ff && b_valid_ff);
         rsp_valid_ff <= rsp_valid_in;
         if (b_advance) begin
            best_cnt_ff <= best_cnt_in;
            best_key_ff <= best_key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_key_ff   <= head_key;
         b_epoch_ff <= head_first ? epoch_ff + 1'b1 : epoch_ff;
         b_first_ff <= head_first;
         b_last_ff  <= head_last;
         b_fine_ff  <= head_fine;
      end
      if (b_advance) begin
         fwd_key_ff  <= b_key_ff;
         fwd_word_ff <= {b_epoch_ff, new_cnt};
      end
      if (b_advance && b_last_ff) begin
         rsp_mode_ff  <= found ? MODE_BITS'(mode_prod) : '0;
         rsp_found_ff <= found;
      end
   end

   qmt_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (pop),
      .rd_addr (head_key),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_us    = rsp_mode_ff;
   assign rsp_mode_found = rsp_found_ff;

   // no item in flight while the store is swept
   a_sweep_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !b_valid_ff && !pop)
      else $error("item in flight during sweep");

   // an item in the update stage never carries the cleared epoch
   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_epoch_ff != '0))
      else $error("item tagged with cleared epoch");

   // a new result only follows a committed last item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b_advance && b_last_ff))
      else $error("result without last item");

   // a sweep only starts with the pipeline drained
   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      start_sweep |=> (state_ff == ST_SWEEP) && (epoch_ff == '0) && !fwd_valid_ff)
      else $error("sweep started with pending update");

endmodule

[hw/rtl/quantized_mode_tracker.sv]
// ----------------------------------------------------------------------------
// quantized_mode_tracker
// streaming histogram mode of sets of round-trip samples
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  sample_us[19:0], first, last
//   rsp      out        rsp_valid/rsp_ready  mode_us[18:0], mode_found
//
// one sample per cycle sustained while no sweep is pending or running and
// rsp is not stalled; the count store takes one read and one write each
// cycle, with the previous item's write forwarded into the update
// a result is registered in the front stage, the queue, the update stage
// and the result register; after reset all 2^KEY_BITS count store entries
// (4096) are swept with req_ready low; the same sweep runs on epoch wrap,
// once every 255 sets (254 after reset); a stalled rsp holds only the update
// stage of a last sample; the queue keeps taking samples until it fills
module quantized_mode_tracker
   import qmt_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_us,
   input  logic                   req_first,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [MODE_BITS-1:0]   rsp_mode_us,
   output logic                   rsp_mode_found
);

   localparam int ENTRY_BITS = KEY_BITS + ENTRY_FLAGS;

   logic                  sweeping;
   logic                  fq_valid, fq_ready;
   logic [ENTRY_BITS-1:0] fq_data;
   logic                  qb_valid, qb_ready;
   logic [ENTRY_BITS-1:0] qb_data;

   qmt_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .hold          (sweeping),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_us (req_sample_us),
      .req_first     (req_first),
      .req_last      (req_last),
      .q_valid       (fq_valid),
      .q_ready       (fq_ready),
      .q_data        (fq_data)
   );

   qmt_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   qmt_back #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .sweeping       (sweeping),
      .q_valid        (qb_valid),
      .q_ready        (qb_ready),
      .q_data         (qb_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mode_us    (rsp_mode_us),
      .rsp_mode_found (rsp_mode_found)
   );

endmodule
